>>> sv/xyzg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the XYZ to sRGB gamut mapper.
// Holds the transaction structs, register indexes, matrix ROM and gamma threshold builder.
// No dependencies.
package xyzg_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_POINT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAMUT_MODE  = 4'd1;

    // White point codes
    localparam logic [1:0] WP_D65      = 2'd0;
    localparam logic [1:0] WP_D50      = 2'd1;
    localparam logic [1:0] WP_E        = 2'd2;
    localparam logic [1:0] WP_RESERVED = 2'd3;

    // Gamut handling codes
    localparam logic GM_CLIP = 1'b0;
    localparam logic GM_GRAY = 1'b1;

    typedef struct packed {
        logic [15:0] x_value;
        logic [15:0] y_value;
        logic [15:0] z_value;
    } t_xyzg_in;

    typedef struct packed {
        logic [7:0] red_code;
        logic [7:0] green_code;
        logic [7:0] blue_code;
        logic       out_of_gamut;
    } t_xyzg_out;

    // XYZ to linear sRGB, signed Q3.14, [white point][row][column]
    localparam logic signed [16:0] XYZG_ROM [3][3][3] = '{
        '{ '{ 17'sd53098, -17'sd25187, -17'sd8169 },
           '{-17'sd15880,  17'sd30735,  17'sd681  },
           '{ 17'sd912,   -17'sd3343,   17'sd17322} },
        '{ '{ 17'sd45147, -17'sd21416, -17'sd6946 },
           '{-17'sd16276,  17'sd31501,  17'sd698  },
           '{ 17'sd1263,  -17'sd4630,   17'sd23990} },
        '{ '{ 17'sd44067, -17'sd20904, -17'sd6780 },
           '{-17'sd16746,  17'sd32412,  17'sd718  },
           '{ 17'sd1003,  -17'sd3678,   17'sd19059} }
    };

    // Smallest table index whose gamma code reaches k; tmax + 1 when none does.
    // Evaluated at elaboration only.
    function automatic longint xyzg_thr(input int k, input longint tmax);
        longint lin_lim;
        longint t_lin;
        longint t_pow;
        longint res;
        real    x;
        lin_lim = (31308 * tmax) / 10000000;
        if (k == 0) begin
            return 0;
        end
        t_lin = (20 * tmax * k - 10 * tmax + 65891) / 65892;
        x     = real'(tmax) * ((real'(200 * k + 2705) / 53805.0) ** 2.4);
        t_pow = longint'($rtoi(x));
        if (real'(t_pow) < x) begin
            t_pow = t_pow + 1;
        end
        if (t_lin <= lin_lim) begin
            res = t_lin;
        end else begin
            res = (t_pow > lin_lim) ? t_pow : lin_lim + 1;
        end
        if (res > tmax) begin
            res = tmax + 1;
        end
        return res;
    endfunction

endpackage

>>> sv/xyzg_mac_lane.sv
`timescale 1ns / 1ps
// One matrix row lane: three products, then a rounded sum to the linear format.
// Depends on xyzg_pkg.
module xyzg_mac_lane #(
    parameter int FRACTION_BITS = 16,
    parameter int ROW           = 0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [1:0]                    i_wp,
    input  xyzg_pkg::t_xyzg_in            i_pix,
    output logic signed [FRACTION_BITS+7:0] o_lin
);
    localparam int LIN_W = FRACTION_BITS + 8;
    localparam int ACC_W = 36;
    localparam logic signed [ACC_W-1:0] RND = 36'sd1 <<< (27 - FRACTION_BITS);

    logic [1:0]               w_wp;
    logic [15:0]              w_px [3];
    logic signed [33:0]       r_p  [3];
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [LIN_W-1:0]  r_lin;

    assign w_wp    = (i_wp == xyzg_pkg::WP_RESERVED) ? xyzg_pkg::WP_D65 : i_wp;
    assign w_px[0] = i_pix.x_value;
    assign w_px[1] = i_pix.y_value;
    assign w_px[2] = i_pix.z_value;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_p[c] <= xyzg_pkg::XYZG_ROM[w_wp][ROW][c] * $signed({1'b0, w_px[c]});
            end
        end
    end

    assign n_acc = ACC_W'(r_p[0]) + ACC_W'(r_p[1]) + ACC_W'(r_p[2]) + RND;

    // Floor shift of the biased sum gives round half up
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lin <= n_acc[ACC_W-1 -: LIN_W];
        end
    end

    assign o_lin = r_lin;
endmodule

>>> sv/xyzg_div_lane.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for one gray limit ratio, saturating at one.
// Depends on nothing beyond its parameter.
module xyzg_div_lane #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [FRACTION_BITS:0]   i_num,
    input  logic [FRACTION_BITS+7:0] i_den,
    output logic [FRACTION_BITS:0]   o_lim
);
    localparam int F  = FRACTION_BITS;
    localparam int DW = F + 8;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    logic          r_sat [F+1];
    logic [DW-1:0] r_rem [F+1];
    logic [DW-1:0] r_d   [F+1];
    logic [F-1:0]  r_q   [F+1];

    // A quotient of one or more means no tighter limit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= DW'(i_num) >= i_den;
            r_rem[0] <= DW'(i_num);
            r_d[0]   <= i_den;
            r_q[0]   <= '0;
        end
    end

    for (genvar s = 1; s <= F; s++) begin : g_step
        logic [DW:0] w_tr;
        logic        w_ge;
        logic [DW:0] w_sub;
        assign w_tr  = {r_rem[s-1], 1'b0};
        assign w_ge  = w_tr >= {1'b0, r_d[s-1]};
        assign w_sub = w_tr - {1'b0, r_d[s-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[s] <= r_sat[s-1];
                r_d[s]   <= r_d[s-1];
                r_rem[s] <= w_ge ? w_sub[DW-1:0] : w_tr[DW-1:0];
                r_q[s]   <= {r_q[s-1][F-2:0], w_ge};
            end
        end
    end

    assign o_lim = r_sat[F] ? ONE : {1'b0, r_q[F]};
endmodule

>>> sv/xyzg_gamma_lane.sv
`timescale 1ns / 1ps
// One channel of the transfer curve: table index, then an 8-step threshold search.
// Depends on xyzg_pkg for the threshold builder.
module xyzg_gamma_lane #(
    parameter int FRACTION_BITS    = 16,
    parameter int GAMMA_TABLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [FRACTION_BITS:0] i_lin,
    output logic [7:0]             o_code
);
    localparam int F  = FRACTION_BITS;
    localparam int G  = GAMMA_TABLE_BITS;
    localparam int PW = F + G + 1;
    localparam longint TMAX = (64'd1 << G) - 64'd1;
    localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

    logic [G:0]    w_thr [256];
    logic [PW-1:0] n_prod;
    logic [G-1:0]  r_idx [9];
    logic [7:0]    r_acc [9];

    for (genvar k = 0; k < 256; k++) begin : g_thr
        localparam logic [G:0] THR_K = (G+1)'(xyzg_pkg::xyzg_thr(k, TMAX));
        assign w_thr[k] = THR_K;
    end

    // lin * (2^G - 1) as a shift and subtract, rounded half up
    assign n_prod = {i_lin, G'(0)} - PW'(i_lin) + HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx[0] <= n_prod[F +: G];
            r_acc[0] <= '0;
        end
    end

    // Settle one code bit per stage, most significant first
    for (genvar s = 0; s < 8; s++) begin : g_srch
        logic [7:0] w_cand;
        logic       w_hit;
        assign w_cand = r_acc[s] | (8'd1 << (7 - s));
        assign w_hit  = w_thr[w_cand] <= {1'b0, r_idx[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_idx[s+1] <= r_idx[s];
                r_acc[s+1] <= w_hit ? w_cand : r_acc[s];
            end
        end
    end

    assign o_code = r_acc[8];
endmodule

>>> sv/xyz_to_srgb_gamut_map_top.sv
`timescale 1ns / 1ps
// Top level of the XYZ to sRGB converter with gamut mapping.
// Depends on xyzg_pkg, xyzg_mac_lane, xyzg_div_lane and xyzg_gamma_lane.
//
// Converts one CIE XYZ pixel (unsigned Q2.14) per transaction to 8-bit sRGB codes.
// Three channel lanes run side by side through the whole pipe: matrix row, gray
// limit divider and transfer curve; the classify stage ORs the lane out-of-gamut
// flags and a merge stage takes the smallest limit ratio. One transaction is
// accepted every clock while input ready is high. From input to output the pipe
// holds two matrix stages, one classify stage, FRACTION_BITS + 1 divider stages,
// minimum, multiply, final select, table index, eight search stages and the output
// register; the divider settles one bit per stage. The output register has a skid
// stage behind it, so input ready is registered and drops only when both hold a
// waiting result. Configure only while idle: index 0 selects the white point (D65,
// D50, E; code 3 acts as D65), index 1 the gamut handling (0 clip, 1 pull toward the
// clamped green gray). Configuration writes are always taken.
module xyz_to_srgb_gamut_map_top #(
    parameter int FRACTION_BITS    = 16,
    parameter int GAMMA_TABLE_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  xyzg_pkg::t_xyzg_in                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output xyzg_pkg::t_xyzg_out                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [xyzg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [xyzg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int F       = FRACTION_BITS;
    localparam int LIN_W   = F + 8;
    localparam int DW      = F + 8;
    localparam int DIV_LAT = F + 1;
    localparam int GAM_LAT = 9;
    localparam int NST     = F + 16;
    localparam logic signed [LIN_W-1:0] ONE_S = LIN_W'(1) << F;
    localparam logic [F:0]              ONE   = (F+1)'(1) << F;

    typedef struct packed {
        logic [2:0][LIN_W-1:0] lin;
        logic [F:0]            g;
        logic                  oog;
        logic [2:0]            ge;
        logic [2:0][DW-1:0]    diff;
    } t_pay;

    // Clamp a signed linear value to [0, ONE]
    function automatic logic [F:0] clamp_lin(input logic signed [LIN_W+1:0] v);
        logic [F:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > (LIN_W+2)'(ONE_S)) begin
            res = ONE;
        end else begin
            res = v[F:0];
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- config
    logic [1:0] r_wp;
    logic       r_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= xyzg_pkg::WP_D65;
            r_mode <= xyzg_pkg::GM_CLIP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                xyzg_pkg::REG_WHITE_POINT: r_wp   <= i_cfg_data[1:0];
                xyzg_pkg::REG_GAMUT_MODE:  r_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ flow control
    // The whole pipe advances together; it halts only while the skid holds data.
    logic           w_en;
    logic [NST-1:0] r_vld;
    logic           r_out_vld;
    logic           r_skid_vld;
    xyzg_pkg::t_xyzg_out r_out;
    xyzg_pkg::t_xyzg_out r_skid;
    xyzg_pkg::t_xyzg_out w_res;
    logic           w_take;

    assign w_en       = !r_skid_vld;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------ matrix lanes
    logic signed [LIN_W-1:0] w_lin [3];

    for (genvar r = 0; r < 3; r++) begin : g_mac
        xyzg_mac_lane #(
            .FRACTION_BITS (F),
            .ROW           (r)
        ) u_mac (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_wp  (r_wp),
            .i_pix (i_in_data),
            .o_lin (w_lin[r])
        );
    end

    // ------------------------------------------------------- classify stage
    // Flag range violations, fix the gray level and set up each limit ratio.
    t_pay       n_c;
    t_pay       r_c;
    logic [F:0] n_num [3];
    logic [F:0] r_num [3];

    always_comb begin
        logic signed [LIN_W-1:0] gs;
        logic signed [LIN_W-1:0] d;
        n_c.g   = clamp_lin((LIN_W+2)'(w_lin[1]));
        gs      = LIN_W'(n_c.g);
        n_c.oog = 1'b0;
        for (int r = 0; r < 3; r++) begin
            n_c.lin[r] = w_lin[r];
            if (w_lin[r] < 0 || w_lin[r] > ONE_S) begin
                n_c.oog = 1'b1;
            end
            n_c.ge[r]   = w_lin[r] >= gs;
            d           = n_c.ge[r] ? (w_lin[r] - gs) : (gs - w_lin[r]);
            n_c.diff[r] = d;
            if (w_lin[r] > gs) begin
                n_num[r] = ONE - n_c.g;
            end else if (w_lin[r] < gs) begin
                n_num[r] = n_c.g;
            end else begin
                n_num[r] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c <= n_c;
            for (int r = 0; r < 3; r++) begin
                r_num[r] <= n_num[r];
            end
        end
    end

    // ------------------------------------------------------ divider lanes
    logic [F:0] w_lim [3];

    for (genvar r = 0; r < 3; r++) begin : g_div
        xyzg_div_lane #(
            .FRACTION_BITS (F)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_num[r]),
            .i_den (r_c.diff[r]),
            .o_lim (w_lim[r])
        );
    end

    // Carry the pixel alongside the dividers
    t_pay r_dl [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl[0] <= r_c;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_dl[s] <= r_dl[s-1];
            end
        end
    end

    // ------------------------------------------------------ merge: minimum
    logic [F:0] n_t;
    logic [F:0] r_t;
    t_pay       r_m;

    always_comb begin
        n_t = w_lim[0];
        if (w_lim[1] < n_t) n_t = w_lim[1];
        if (w_lim[2] < n_t) n_t = w_lim[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t <= n_t;
            r_m <= r_dl[DIV_LAT-1];
        end
    end

    // ------------------------------------------------------ scale stage
    logic [F+DW:0] r_prod [3];
    t_pay          r_p;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                r_prod[r] <= r_t * r_m.diff[r];
            end
            r_p <= r_m;
        end
    end

    // ------------------------------------------------------ final select
    logic [F:0] n_fin [3];
    logic [F:0] r_fin [3];
    logic       r_fin_oog;

    always_comb begin
        logic signed [LIN_W+1:0] step;
        logic signed [LIN_W+1:0] moved;
        logic signed [LIN_W+1:0] gx;
        gx = (LIN_W+2)'(r_p.g);
        for (int r = 0; r < 3; r++) begin
            step  = (LIN_W+2)'(r_prod[r][F +: DW+1]);
            moved = r_p.ge[r] ? (gx + step) : (gx - step);
            if (!r_p.oog) begin
                n_fin[r] = r_p.lin[r][F:0];
            end else if (r_mode == xyzg_pkg::GM_CLIP) begin
                n_fin[r] = clamp_lin((LIN_W+2)'($signed(r_p.lin[r])));
            end else begin
                n_fin[r] = clamp_lin(moved);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                r_fin[r] <= n_fin[r];
            end
            r_fin_oog <= r_p.oog;
        end
    end

    // ------------------------------------------------------ gamma lanes
    logic [7:0] w_code [3];
    logic       r_oog_dl [GAM_LAT];

    for (genvar r = 0; r < 3; r++) begin : g_gam
        xyzg_gamma_lane #(
            .FRACTION_BITS    (F),
            .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
        ) u_gam (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lin  (r_fin[r]),
            .o_code (w_code[r])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_oog_dl[0] <= r_fin_oog;
            for (int s = 1; s < GAM_LAT; s++) begin
                r_oog_dl[s] <= r_oog_dl[s-1];
            end
        end
    end

    assign w_res.red_code     = w_code[0];
    assign w_res.green_code   = w_code[1];
    assign w_res.blue_code    = w_code[2];
    assign w_res.out_of_gamut = r_oog_dl[GAM_LAT-1];

    // ------------------------------------------------ output register and skid
    // Park an arriving result in the skid when the output is still held.
    assign w_take = r_out_vld && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[NST-1]) begin
            if (!r_out_vld || w_take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (r_vld[NST-1]) begin
            if (!r_out_vld || w_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a transaction while the output register is empty");

    a_skid_after_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_out_ready))
        else $error("skid filled without a stalled output");

    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_vld[NST-1]))
        else $error("output became valid with no transaction leaving the pipe");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[F+4] |-> (r_t <= ONE))
        else $error("gray limit ratio above one");
`endif
endmodule
